@@ hw/rtl/ctdfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctdfp_pkg: shared types and constants of the CTD frame parser
// Holds the controller states, the command and status structs, the sync word
// and the calibration coefficient tables.
// ----------------------------------------------------------------------------
package ctdfp_pkg;

  localparam int FRAME_LEN_DEF = 128;

  localparam logic [31:0] SYNC_WORD   = 32'h4543_4536;
  localparam logic [3:0]  HEADER_SKIP = 4'd11;

  localparam int CODE_W = 5;
  localparam int CH_W   = 2;
  localparam int NUM_CH = 3;
  localparam int RAW_W  = 16;
  localparam int VAL_W  = 32;
  localparam int ACC_W  = 64;
  localparam int OUT_W  = 152;
  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] LAST_STEP = 5'd17;

  // Channel numbers, also the configuration register indexes.
  localparam logic [CH_W-1:0] CH_DEPTH = 2'd0;
  localparam logic [CH_W-1:0] CH_TEMP  = 2'd1;
  localparam logic [CH_W-1:0] CH_COND  = 2'd2;

  localparam logic [CODE_W-1:0] DEPTH_CODE_RST = 5'd0;
  localparam logic [CODE_W-1:0] TEMP_CODE_RST  = 5'd1;
  localparam logic [CODE_W-1:0] COND_CODE_RST  = 5'd2;

  typedef enum logic [2:0] {
    ST_SEARCH,
    ST_HEADER,
    ST_RECORD,
    ST_CALC,
    ST_DONE,
    ST_NOSYNC
  } ctl_state_t;

  typedef enum logic [1:0] {
    PH_NONE,
    PH_SEARCH,
    PH_HEADER,
    PH_RECORD
  } phase_t;

  typedef enum logic [1:0] {
    RND_0,
    RND_12,
    RND_16
  } rnd_t;

  typedef struct packed {
    phase_t          phase;
    logic            acc_init;
    logic            ld_coef;
    logic [1:0]      coef_k;
    logic            mul_lo;
    logic            mul_hi;
    logic            round_en;
    logic [1:0]      round_k;
    logic            acc_add;
    logic            finish;
    logic [CH_W-1:0] ch;
    logic            load_out;
    logic            out_status;
    logic            frame_clear;
  } ctl_cmd_t;

  typedef struct packed {
    logic last_byte;
    logic sync_hit;
    logic header_done;
    logic out_busy;
  } dp_status_t;

  // Coefficient k of a channel, as an integer at scale 2^-48, 2^-60 or 2^-64.
  function automatic logic signed [ACC_W-1:0] coef(input logic [CH_W-1:0] ch,
                                                   input logic [1:0] k);
    logic signed [ACC_W-1:0] c;
    case ({ch, k})
      {CH_DEPTH, 2'd0}: c = -64'sd70699195800322310;
      {CH_DEPTH, 2'd1}: c =  64'sd9933167485626;
      {CH_DEPTH, 2'd2}: c =  64'sd231084669;
      {CH_DEPTH, 2'd3}: c = -64'sd12901;
      {CH_TEMP,  2'd0}: c = -64'sd726644540877161;
      {CH_TEMP,  2'd1}: c =  64'sd166182544775;
      {CH_COND,  2'd0}: c = -64'sd77658101649540;
      {CH_COND,  2'd1}: c =  64'sd343855461049;
      {CH_COND,  2'd2}: c =  64'sd291646483;
      {CH_COND,  2'd3}: c = -64'sd14213;
      default:          c = '0;
    endcase
    return c;
  endfunction

  // Right shift that brings term k of a channel to scale 2^-48.
  function automatic rnd_t term_rnd(input logic [CH_W-1:0] ch, input logic [1:0] k);
    rnd_t r;
    r = RND_0;
    if (ch == CH_DEPTH && (k == 2'd2 || k == 2'd3)) begin
      r = RND_12;
    end else if (ch == CH_COND && k == 2'd2) begin
      r = RND_12;
    end else if (ch == CH_COND && k == 2'd3) begin
      r = RND_16;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ctdfp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctdfp_ctrl: frame controller
// Tracks the parse phase of the frame and sequences the calibration steps
// over the shared multiplier, one channel after the other.
// ----------------------------------------------------------------------------
module ctdfp_ctrl
  import ctdfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_acc,
  input  wire dp_status_t status,
  output logic            in_ready,
  output ctl_cmd_t        cmd
);

  ctl_state_t        state;
  ctl_state_t        state_next;
  logic [STEP_W-1:0] step_cnt;
  logic [CH_W-1:0]   ch_cnt;
  logic              calc_done;

  assign calc_done = (state == ST_CALC) && (step_cnt == LAST_STEP) && (ch_cnt == CH_COND);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_SEARCH;
      step_cnt <= '0;
      ch_cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CALC) begin
        if (step_cnt == LAST_STEP) begin
          step_cnt <= '0;
          ch_cnt   <= ch_cnt + 1'b1;
        end else begin
          step_cnt <= step_cnt + 1'b1;
        end
      end else begin
        step_cnt <= '0;
        ch_cnt   <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_SEARCH: begin
        if (byte_acc) begin
          if (status.last_byte) begin
            state_next = ST_NOSYNC;
          end else if (status.sync_hit) begin
            state_next = ST_HEADER;
          end
        end
      end
      ST_HEADER: begin
        if (byte_acc) begin
          if (status.last_byte) begin
            state_next = ST_CALC;
          end else if (status.header_done) begin
            state_next = ST_RECORD;
          end
        end
      end
      ST_RECORD: begin
        if (byte_acc && status.last_byte) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (calc_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE, ST_NOSYNC: begin
        if (!status.out_busy) begin
          state_next = ST_SEARCH;
        end
      end
      default: state_next = ST_SEARCH;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_SEARCH: begin
        in_ready  = 1'b1;
        cmd.phase = PH_SEARCH;
      end
      ST_HEADER: begin
        in_ready  = 1'b1;
        cmd.phase = PH_HEADER;
      end
      ST_RECORD: begin
        in_ready  = 1'b1;
        cmd.phase = PH_RECORD;
      end
      ST_CALC: begin
        cmd.ch = ch_cnt;
        // Cubic in the raw value x: C3*x*x*x, then C2*x*x, then C1*x, each
        // product built from two half-width multiplies.
        case (step_cnt)
          5'd0: begin
            cmd.acc_init = 1'b1;
            cmd.ld_coef  = 1'b1;
            cmd.coef_k   = 2'd3;
          end
          5'd1, 5'd3, 5'd5, 5'd10: cmd.mul_lo = 1'b1;
          5'd2, 5'd4, 5'd6, 5'd9, 5'd11, 5'd14: cmd.mul_hi = 1'b1;
          5'd7: begin
            cmd.round_en = 1'b1;
            cmd.round_k  = 2'd3;
            cmd.ld_coef  = 1'b1;
            cmd.coef_k   = 2'd2;
          end
          5'd8, 5'd13: begin
            cmd.acc_add = 1'b1;
            cmd.mul_lo  = 1'b1;
          end
          5'd12: begin
            cmd.round_en = 1'b1;
            cmd.round_k  = 2'd2;
            cmd.ld_coef  = 1'b1;
            cmd.coef_k   = 2'd1;
          end
          5'd15: begin
            cmd.round_en = 1'b1;
            cmd.round_k  = 2'd1;
          end
          5'd16: cmd.acc_add = 1'b1;
          5'd17: cmd.finish  = 1'b1;
          default: cmd.finish = 1'b0;
        endcase
      end
      ST_DONE: begin
        cmd.load_out    = !status.out_busy;
        cmd.frame_clear = !status.out_busy;
      end
      ST_NOSYNC: begin
        cmd.load_out    = !status.out_busy;
        cmd.frame_clear = !status.out_busy;
        cmd.out_status  = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/ctdfp_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctdfp_dpath: parse and calibration datapath
// Byte counter, sync window, record assembly, held samples, the shared
// multiplier with accumulator, and the output register.
// ----------------------------------------------------------------------------
module ctdfp_dpath
  import ctdfp_pkg::*;
#(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CH_W-1:0]   cfg_index,
  input  wire logic [CODE_W-1:0] cfg_data,
  input  wire logic              byte_acc,
  input  wire logic [7:0]        rx_byte,
  input  wire ctl_cmd_t          cmd,
  input  wire logic              out_ready,
  output dp_status_t             status,
  output logic                   out_valid,
  output logic [OUT_W-1:0]       out_data
);

  localparam int CNT_W = $clog2(FRAME_LEN);
  localparam logic [CNT_W-1:0] LAST_POS  = CNT_W'(FRAME_LEN - 1);
  localparam logic [CNT_W-1:0] SYNC_LAST = CNT_W'(FRAME_LEN - 25);

  logic [CODE_W-1:0] code_q [NUM_CH];
  logic [CNT_W-1:0]  byte_count;
  logic [31:0]       sync_window;
  logic [31:0]       window_next;
  logic [3:0]        header_left;
  logic [7:0]        rec_b0;
  logic [7:0]        rec_b1;
  logic [1:0]        record_pos;
  logic [2:0]        found_flags;
  logic [RAW_W-1:0]  raw_q [NUM_CH];
  logic [VAL_W-1:0]  cal_q [NUM_CH];

  logic [CODE_W-1:0] rec_code;
  logic              take_hit;
  logic [CH_W-1:0]   take_ch;
  logic [RAW_W-1:0]  take_raw;

  logic signed [ACC_W-1:0] mul_a;
  logic [47:0]             mul_lo_q;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc;
  logic [RAW_W-1:0]        x;
  logic [47:0]             lo_prod;
  logic signed [48:0]      hi_prod;
  logic [ACC_W-1:0]        mul_full;
  rnd_t                    rnd;
  logic signed [ACC_W-1:0] rnd_bias;
  logic signed [ACC_W-1:0] rnd_sum;
  logic signed [ACC_W-1:0] term_in;
  logic signed [ACC_W:0]   fin_sum;
  logic signed [VAL_W:0]   fin_q;
  logic [VAL_W-1:0]        fin_sat;

  // ---------------- parse status ----------------
  assign window_next        = {sync_window[23:0], rx_byte};
  assign status.last_byte   = (byte_count == LAST_POS);
  assign status.sync_hit    = (cmd.phase == PH_SEARCH) && (window_next == SYNC_WORD) &&
                              (byte_count <= SYNC_LAST);
  assign status.header_done = (header_left == 4'd1);
  assign status.out_busy    = out_valid && !out_ready;

  assign rec_code = rx_byte[7:3];
  assign take_raw = {rx_byte[2:1], rec_b1[7:1], rec_b0[7:1]};

  // Equal codes resolve toward depth, then temperature.
  always_comb begin
    take_hit = 1'b1;
    take_ch  = CH_DEPTH;
    priority if (rec_code == code_q[CH_DEPTH]) begin
      take_ch = CH_DEPTH;
    end else if (rec_code == code_q[CH_TEMP]) begin
      take_ch = CH_TEMP;
    end else if (rec_code == code_q[CH_COND]) begin
      take_ch = CH_COND;
    end else begin
      take_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_q[CH_DEPTH] <= DEPTH_CODE_RST;
      code_q[CH_TEMP]  <= TEMP_CODE_RST;
      code_q[CH_COND]  <= COND_CODE_RST;
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (cfg_index == CH_W'(i)) begin
          code_q[i] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.frame_clear) begin
      byte_count  <= '0;
      sync_window <= '0;
      header_left <= '0;
      rec_b0      <= '0;
      rec_b1      <= '0;
      record_pos  <= '0;
      found_flags <= '0;
    end else if (byte_acc) begin
      byte_count <= byte_count + 1'b1;
      unique case (cmd.phase)
        PH_SEARCH: begin
          sync_window <= window_next;
          if (status.sync_hit) begin
            header_left <= HEADER_SKIP;
          end
        end
        PH_HEADER: begin
          if (header_left != 4'd0) begin
            header_left <= header_left - 1'b1;
          end
          if (status.header_done) begin
            record_pos <= 2'd0;
          end
        end
        PH_RECORD: begin
          unique case (record_pos)
            2'd0: begin
              rec_b0     <= rx_byte;
              rec_b1     <= '0;
              record_pos <= 2'd1;
            end
            2'd1: begin
              rec_b1     <= rx_byte;
              record_pos <= 2'd2;
            end
            default: begin
              record_pos <= 2'd0;
              if (take_hit && !found_flags[take_ch]) begin
                found_flags[take_ch] <= 1'b1;
              end
            end
          endcase
        end
        default: begin
          byte_count <= byte_count + 1'b1;
        end
      endcase
    end
  end

  // ---------------- held samples and calibrated values ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        raw_q[i] <= '0;
        cal_q[i] <= '0;
      end
    end else begin
      if (byte_acc && cmd.phase == PH_RECORD && record_pos == 2'd2 && take_hit &&
          !found_flags[take_ch]) begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (take_ch == CH_W'(i)) begin
            raw_q[i] <= take_raw;
          end
        end
      end
      if (cmd.finish) begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (cmd.ch == CH_W'(i)) begin
            cal_q[i] <= fin_sat;
          end
        end
      end
    end
  end

  // ---------------- shared multiplier and accumulator ----------------
  always_comb begin
    unique case (cmd.ch)
      CH_TEMP: x = raw_q[CH_TEMP];
      CH_COND: x = raw_q[CH_COND];
      default: x = raw_q[CH_DEPTH];
    endcase
  end

  // A 64-bit operand times x in two halves: low word unsigned, high word signed.
  assign lo_prod  = {16'd0, mul_a[31:0]} * {32'd0, x};
  assign hi_prod  = 49'(signed'(mul_a[63:32])) * 49'(signed'({1'b0, x}));
  assign mul_full = {hi_prod[31:0], 32'd0} + {16'd0, mul_lo_q};

  // Round half away from zero: add half the divisor, less one when negative.
  assign rnd = term_rnd(cmd.ch, cmd.round_k);

  always_comb begin
    rnd_bias = '0;
    term_in  = mul_a;
    unique case (rnd)
      RND_12:  rnd_bias = 64'sd2048 - ACC_W'(mul_a[ACC_W-1]);
      RND_16:  rnd_bias = 64'sd32768 - ACC_W'(mul_a[ACC_W-1]);
      default: rnd_bias = '0;
    endcase
    rnd_sum = mul_a + rnd_bias;
    unique case (rnd)
      RND_12:  term_in = rnd_sum >>> 12;
      RND_16:  term_in = rnd_sum >>> 16;
      default: term_in = mul_a;
    endcase
  end

  assign fin_sum = (ACC_W+1)'(acc) + 65'sd2147483648 - (ACC_W+1)'(acc[ACC_W-1]);
  assign fin_q   = fin_sum[ACC_W:32];

  always_comb begin
    if (fin_q > 33'sd2147483647) begin
      fin_sat = 32'h7FFF_FFFF;
    end else if (fin_q < -33'sd2147483648) begin
      fin_sat = 32'h8000_0000;
    end else begin
      fin_sat = fin_q[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_coef) begin
      mul_a <= coef(cmd.ch, cmd.coef_k);
    end else if (cmd.mul_hi) begin
      mul_a <= mul_full;
    end
    if (cmd.mul_lo) begin
      mul_lo_q <= lo_prod;
    end
    if (cmd.round_en) begin
      term <= term_in;
    end
    if (cmd.acc_init) begin
      acc <= coef(cmd.ch, 2'd0);
    end else if (cmd.acc_add) begin
      acc <= acc + term;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {4'd0,
                   cal_q[CH_COND], cal_q[CH_TEMP], cal_q[CH_DEPTH],
                   raw_q[CH_COND], raw_q[CH_TEMP], raw_q[CH_DEPTH],
                   (cmd.out_status ? 3'd0 : found_flags), cmd.out_status};
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ctd_frame_parse_calibrate.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctd_frame_parse_calibrate: CTD sensor frame parser and calibrator
// Parses fixed-length sensor frames byte by byte and reports raw and
// calibrated depth, temperature and conductivity once per frame.
// ----------------------------------------------------------------------------
// Usage:
// Frame bytes enter on the s_axis channel, one byte per transaction. Every
// FRAME_LEN bytes form one frame. During the frame the block takes one byte
// per cycle. After the last byte of a frame it produces exactly one result
// transaction on m_axis.
// When the frame held a valid sync pattern, the three channel polynomials are
// evaluated on one shared multiplier, one channel after the other, before the
// result is loaded. When no sync was found, the result is loaded with no
// calibration pass. In both cases s_axis_tready is low from the last byte
// until the result is loaded into the output register.
// The output register lets the next frame stream in while the previous
// result waits. If m_axis_tready is still low when the next result is due,
// the block holds that result back and keeps s_axis_tready low.
// Reset restores the default record codes, clears the held samples and the
// calibrated values, and starts a frame at byte zero. cfg writes complete in
// the cycle they are presented and should only be issued while idle.
// ----------------------------------------------------------------------------
module ctd_frame_parse_calibrate
  import ctdfp_pkg::*;
#(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Frame byte input.
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  // One result per frame.
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [0] status, [3:1] found_mask, [19:4] depth_raw, [35:20] temp_raw,
  // [51:36] cond_raw, [83:52] depth_value, [115:84] temp_value,
  // [147:116] cond_value, [151:148] zero
  output logic [OUT_W-1:0]       m_axis_tdata,
  // Register writes: index 0 depth_code, 1 temp_code, 2 cond_code.
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CH_W-1:0]   cfg_index,
  input  wire logic [CODE_W-1:0] cfg_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       in_ready;
  logic       byte_acc;

  // Register writes never stall.
  assign cfg_ready     = 1'b1;
  assign s_axis_tready = in_ready;
  assign byte_acc      = s_axis_tvalid && in_ready;

  ctdfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .byte_acc (byte_acc),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ctdfp_dpath #(
    .FRAME_LEN (FRAME_LEN)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_acc  (byte_acc),
    .rx_byte   (s_axis_tdata),
    .cmd       (cmd),
    .out_ready (m_axis_tready),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule
`default_nettype wire

@@ hw/rtl/ctdfp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctdfp_checker: port-level checks of the CTD frame parser
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module ctdfp_checker
  import ctdfp_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A frame without sync reports no captured channel.
  a_nosync_mask: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[3:1] == 3'd0)
    else $error("found_mask set on a frame without sync");

  // After reset the block is ready for the first byte of a frame.
  a_reset_ready: assert property (@(posedge clk)
    rst |=> s_axis_tready)
    else $error("input not ready after reset");

  // A new result is only loaded while the input side is closed.
  a_result_after_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while bytes were being taken");

endmodule

bind ctd_frame_parse_calibrate ctdfp_checker u_ctdfp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ dv/ctd_frame_parse_calibrate_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctd_frame_parse_calibrate_tb: self-checking bench for the CTD frame parser
// Streams whole sensor frames into the block and predicts the one result per
// frame with its own parser and calibration polynomials. Each result
// transaction is compared field by field. Directed frames cover the sync
// window, record handling and the code registers. They are followed by random
// frames, random idle gaps on the input, stall patterns on the output and a
// long output hold-off.
// ----------------------------------------------------------------------------
module ctd_frame_parse_calibrate_tb;
  import ctdfp_pkg::*;

  localparam int FRAME_LEN = 128;
  // Sync word as it shifts in, first byte in the top bits.
  localparam logic [31:0] SYNC_PATTERN = 32'h4543_4536;
  // Header bytes that follow the last sync byte before the first record.
  localparam int HDR_AFTER_SYNC = 11;
  // Latest frame position of the first sync byte that still counts.
  localparam int SYNC_LAST_START = FRAME_LEN - 28;
  // Cycles a parsed frame may spend in the calibration pass, with margin.
  localparam int CALC_SETTLE = 64;
  localparam int CYCLE_LIMIT = 500000;
  // The one register index that the port can carry but the block does not use.
  localparam logic [CH_W-1:0] CFG_IDX_SPARE = 2'd3;

  // One result transaction, laid out exactly as m_axis_tdata.
  typedef struct packed {
    logic [3:0]         pad;
    logic signed [31:0] cond_value;
    logic signed [31:0] temp_value;
    logic signed [31:0] depth_value;
    logic [15:0]        cond_raw;
    logic [15:0]        temp_raw;
    logic [15:0]        depth_raw;
    logic [2:0]         found_mask;
    logic               status;
  } frame_result_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = 8'h00;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CH_W-1:0]   cfg_index = '0;
  logic [CODE_W-1:0] cfg_data = '0;

  ctd_frame_parse_calibrate #(
    .FRAME_LEN(FRAME_LEN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Calibration coefficients as integers, and the right shift that brings
  // each term to the common scale of 2^-48.
  longint cal_coef [3][4] = '{
    '{-64'sd70699195800322310, 64'sd9933167485626, 64'sd231084669, -64'sd12901},
    '{-64'sd726644540877161, 64'sd166182544775, 64'sd0, 64'sd0},
    '{-64'sd77658101649540, 64'sd343855461049, 64'sd291646483, -64'sd14213}
  };
  int cal_drop [3][4] = '{'{0, 0, 12, 12}, '{0, 0, 0, 0}, '{0, 0, 12, 16}};

  // Parser state of the prediction, at its reset values.
  logic [CODE_W-1:0]  pf_code [3] = '{5'd0, 5'd1, 5'd2};
  int                 pf_count = 0;
  logic [31:0]        pf_window = '0;
  phase_t             pf_phase = PH_SEARCH;
  int                 pf_hdr_left = 0;
  logic [15:0]        pf_rec_hold = '0;
  int                 pf_rec_pos = 0;
  logic [2:0]         pf_found = '0;
  logic [15:0]        pf_raw [3] = '{16'd0, 16'd0, 16'd0};
  logic signed [31:0] pf_cal [3] = '{32'sd0, 32'sd0, 32'sd0};

  frame_result_t frame_results_due [$];
  frame_result_t want_result;
  frame_result_t got_result;

  logic [7:0] frame_bytes [FRAME_LEN];

  int errors = 0;
  int frames_sent = 0;
  int frames_unsynced = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  // Sender burst control. Only the stimulus process touches these.
  int burst_left = 0;
  bit tx_gaps_on = 1'b1;

  // Receiver controls; the stimulus process changes them with nonblocking
  // assignments so the receiver always picks them up at the next edge.
  bit          rx_stall_on = 1'b1;
  int          rx_hold_len = 0;
  int          rx_hold_tag = 0;
  int          rx_hold_seen = 0;
  int          rx_hold_left = 0;
  logic [15:0] rx_pattern = 16'hB5D3;
  logic [7:0]  rx_age = 8'd1;

  // Divide by 2^sh, rounding half away from zero.
  function automatic longint shift_round(input longint t, input int sh);
    longint d;
    longint h;
    if (sh == 0) return t;
    d = longint'(1) << sh;
    h = d / 2;
    if (t >= 0) return (t + h) / d;
    return -((-t + h) / d);
  endfunction

  // Polynomial of one channel in the raw sample, as saturated Q16.16.
  function automatic logic signed [31:0] calibrate_q16(input int ch, input logic [15:0] x);
    longint acc;
    longint term;
    longint pw;
    longint q;
    int k;
    acc = 0;
    pw = 1;
    for (k = 0; k < 4; k++) begin
      term = cal_coef[ch][k] * pw;
      acc += shift_round(term, cal_drop[ch][k]);
      pw = pw * longint'({48'd0, x});
    end
    q = shift_round(acc, 32);
    if (q > 64'sd2147483647) begin
      q = 64'sd2147483647;
    end else if (q < -64'sd2147483648) begin
      q = -64'sd2147483648;
    end
    return q[31:0];
  endfunction

  // Advance the predicted parser by one accepted byte. The last byte of a
  // frame queues the result that the block owes for it.
  function automatic void parse_frame_byte(input logic [7:0] b);
    int pos;
    int ch;
    frame_result_t r;
    pos = pf_count;
    case (pf_phase)
      PH_HEADER: begin
        if (pf_hdr_left > 0) pf_hdr_left--;
        if (pf_hdr_left == 0) begin
          pf_phase = PH_RECORD;
          pf_rec_pos = 0;
        end
      end
      PH_RECORD: begin
        if (pf_rec_pos == 0) begin
          pf_rec_hold = {8'h00, b};
          pf_rec_pos = 1;
        end else if (pf_rec_pos == 1) begin
          pf_rec_hold[15:8] = b;
          pf_rec_pos = 2;
        end else begin
          // Depth wins over temperature, temperature over conductivity.
          if (b[7:3] == pf_code[0]) ch = 0;
          else if (b[7:3] == pf_code[1]) ch = 1;
          else if (b[7:3] == pf_code[2]) ch = 2;
          else ch = -1;
          if (ch >= 0 && !pf_found[ch]) begin
            pf_raw[ch] = {b[2:1], pf_rec_hold[15:9], pf_rec_hold[7:1]};
            pf_found[ch] = 1'b1;
          end
          pf_rec_pos = 0;
        end
      end
      default: begin
        pf_window = {pf_window[23:0], b};
        // pos is the last sync byte; the first one sits three bytes earlier.
        if (pf_window == SYNC_PATTERN && pos - 3 <= SYNC_LAST_START) begin
          pf_phase = PH_HEADER;
          pf_hdr_left = HDR_AFTER_SYNC;
        end
      end
    endcase

    if (pos + 1 < FRAME_LEN) begin
      pf_count = pos + 1;
      return;
    end

    r = '0;
    if (pf_phase == PH_SEARCH) begin
      r.status = 1'b1;
      frames_unsynced++;
    end else begin
      for (ch = 0; ch < 3; ch++) pf_cal[ch] = calibrate_q16(ch, pf_raw[ch]);
      r.found_mask = pf_found;
    end
    r.depth_raw = pf_raw[0];
    r.temp_raw = pf_raw[1];
    r.cond_raw = pf_raw[2];
    r.depth_value = pf_cal[0];
    r.temp_value = pf_cal[1];
    r.cond_value = pf_cal[2];
    frame_results_due.push_back(r);

    pf_count = 0;
    pf_window = '0;
    pf_phase = PH_SEARCH;
    pf_hdr_left = 0;
    pf_rec_hold = '0;
    pf_rec_pos = 0;
    pf_found = '0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Checker: every result transaction against the oldest predicted frame.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_result = frame_result_t'(m_axis_tdata);
      results_checked++;
      if (frame_results_due.size() == 0) begin
        $display("%0t: result with no frame pending, expected none, actual %h",
                 $time, m_axis_tdata);
        errors++;
      end else begin
        want_result = frame_results_due.pop_front();
        check_field("status", want_result.status, got_result.status);
        check_field("found_mask", want_result.found_mask, got_result.found_mask);
        check_field("depth_raw", want_result.depth_raw, got_result.depth_raw);
        check_field("temp_raw", want_result.temp_raw, got_result.temp_raw);
        check_field("cond_raw", want_result.cond_raw, got_result.cond_raw);
        check_field("depth_value", want_result.depth_value, got_result.depth_value);
        check_field("temp_value", want_result.temp_value, got_result.temp_value);
        check_field("cond_value", want_result.cond_value, got_result.cond_value);
        check_field("pad", want_result.pad, got_result.pad);
      end
    end
  end

  // Receiver: a rotating stall pattern that is redrawn each time the 8-bit
  // rx_age counter wraps, or a long hold-off when the stimulus asks for one. The
  // pattern always keeps some ready cycles so a stall never lasts forever.
  always @(posedge clk) begin
    rx_age <= rx_age + 8'd1;
    if (rx_age == 8'd0) begin
      rx_pattern <= 16'($urandom) | 16'h0101;
    end else begin
      rx_pattern <= {rx_pattern[14:0], rx_pattern[15]};
    end
    if (rx_hold_tag != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_tag;
      rx_hold_left <= rx_hold_len;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rx_stall_on ? rx_pattern[15] : 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stopped at the cycle limit, %0d results still due",
               $time, frame_results_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one byte and wait for its transaction. A new burst may start with
  // an idle gap while input gaps are on.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(48, 1);
      gap = tx_gaps_on ? $urandom_range(7, 0) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    parse_frame_byte(b);
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < FRAME_LEN; i++) send_byte(frame_bytes[i]);
    frames_sent++;
  endtask

  // Stop sending and let every owed result drain, then give the block time
  // to settle before anything that needs it idle.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (CALC_SETTLE) @(posedge clk);
  endtask

  // Place one 3-byte record; the bits the parser drops are random.
  function automatic void put_record(input int p, input logic [CODE_W-1:0] code,
                                     input logic [15:0] raw);
    frame_bytes[p] = {raw[6:0], 1'($urandom)};
    frame_bytes[p + 1] = {raw[13:7], 1'($urandom)};
    frame_bytes[p + 2] = {code, raw[15:14], 1'($urandom)};
  endfunction

  // A code in use (known_pct percent of the time) or one that matches no
  // register.
  function automatic logic [CODE_W-1:0] pick_code(input int known_pct);
    logic [CODE_W-1:0] c;
    if ($urandom_range(99, 0) < known_pct) return pf_code[$urandom_range(2, 0)];
    do c = 5'($urandom); while (c == pf_code[0] || c == pf_code[1] || c == pf_code[2]);
    return c;
  endfunction

  // Fill frame_bytes: noise, an optional broken sync pattern ahead of the
  // real one, and from sync_at on the sync word, the header and records up
  // to the end of the frame. A negative sync_at writes no real one.
  task automatic build_frame(input int sync_at, input int known_pct, input bit partial);
    int i;
    int q;
    for (i = 0; i < FRAME_LEN; i++) frame_bytes[i] = 8'($urandom);
    if (partial && (sync_at < 0 || sync_at >= 4)) begin
      q = $urandom_range((sync_at < 0) ? FRAME_LEN - 4 : sync_at - 4, 0);
      frame_bytes[q] = 8'h45;
      frame_bytes[q + 1] = 8'h43;
      frame_bytes[q + 2] = 8'h45;
      frame_bytes[q + 3] = 8'h37;
    end
    if (sync_at >= 0) begin
      for (i = 0; i < 4 && sync_at + i < FRAME_LEN; i++) begin
        frame_bytes[sync_at + i] = SYNC_PATTERN[31 - 8 * i -: 8];
      end
      for (i = sync_at + 15; i + 3 <= FRAME_LEN; i += 3) begin
        put_record(i, pick_code(known_pct), 16'($urandom));
      end
    end
  endtask

  task automatic write_code_reg(input logic [CH_W-1:0] idx, input logic [CODE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx != CFG_IDX_SPARE) pf_code[idx] = val;
    cfg_writes++;
  endtask

  task automatic set_codes(input logic [CODE_W-1:0] d, input logic [CODE_W-1:0] t,
                           input logic [CODE_W-1:0] c);
    wait_results_drained();
    write_code_reg(CH_DEPTH, d);
    write_code_reg(CH_TEMP, t);
    write_code_reg(CH_COND, c);
    cfg_valid <= 1'b0;
  endtask

  // Reset codes: extreme raw values, a repeated and an unknown record, the
  // trailing two bytes that never make a record, then frames where channels
  // are missing and must keep their old samples.
  task automatic test_first_records();
    build_frame(0, 100, 1'b0);
    put_record(15, pf_code[0], 16'hFFFF);
    put_record(18, pf_code[1], 16'h0000);
    put_record(21, pf_code[2], 16'h8001);
    put_record(24, pf_code[0], 16'h1234);
    put_record(27, 5'd31, 16'h5555);
    send_frame();
    build_frame(5, 0, 1'b0);
    put_record(20, pf_code[1], 16'hFFFF);
    send_frame();
    build_frame(1, 0, 1'b0);
    send_frame();
  endtask

  // A frame with only a broken pattern, then overlapping sync bytes where
  // the real pattern starts two bytes in.
  task automatic test_absent_sync();
    build_frame(-1, 0, 1'b1);
    send_frame();
    build_frame(2, 80, 1'b0);
    frame_bytes[0] = 8'h45;
    frame_bytes[1] = 8'h43;
    send_frame();
  endtask

  // Sync at the last position that counts, one past it, and in the last
  // four bytes of the frame.
  task automatic test_sync_window_edge();
    build_frame(SYNC_LAST_START, 100, 1'b0);
    send_frame();
    build_frame(SYNC_LAST_START + 1, 100, 1'b0);
    send_frame();
    build_frame(FRAME_LEN - 4, 100, 1'b0);
    send_frame();
  endtask

  // The spare index, extreme codes and shared codes with their priority.
  task automatic test_code_registers();
    wait_results_drained();
    write_code_reg(CFG_IDX_SPARE, 5'd7);
    cfg_valid <= 1'b0;
    build_frame(0, 0, 1'b0);
    put_record(15, 5'd7, 16'($urandom));
    put_record(18, pf_code[0], 16'hFFFF);
    send_frame();

    set_codes(5'd31, 5'd0, 5'd0);
    build_frame(0, 100, 1'b0);
    put_record(15, 5'd0, 16'h7FFF);
    put_record(18, 5'd31, 16'h0001);
    send_frame();

    set_codes(5'd31, 5'd31, 5'd31);
    build_frame(3, 100, 1'b0);
    send_frame();

    set_codes(5'd10, 5'd20, 5'd10);
    build_frame(0, 100, 1'b0);
    send_frame();
  endtask

  // Mostly well-formed frames with random records, some with the sync near
  // or past the window limit, some noise only. Every eight frames the codes
  // change and the idling on both sides switches on or off.
  task automatic test_random_frames(input int n_frames);
    int f;
    int kind;
    int seg;
    logic [CODE_W-1:0] d;
    logic [CODE_W-1:0] t;
    logic [CODE_W-1:0] c;
    for (f = 0; f < n_frames; f++) begin
      if (f % 8 == 0) begin
        seg = f / 8;
        d = 5'($urandom);
        t = 5'($urandom);
        c = 5'($urandom);
        case ($urandom_range(3, 0))
          0: begin
            t = d;
            c = d;
          end
          1: c = t;
          default: ;
        endcase
        set_codes(d, t, c);
        tx_gaps_on = (seg % 3 != 2);
        rx_stall_on <= (seg % 4 != 3);
      end
      kind = $urandom_range(99, 0);
      if (kind < 65) begin
        build_frame($urandom_range(20, 0), 80, $urandom_range(3, 0) == 0);
      end else if (kind < 75) begin
        build_frame(SYNC_LAST_START - $urandom_range(3, 0), 80, 1'b1);
      end else if (kind < 85) begin
        build_frame(-1, 0, $urandom_range(1, 0) == 0);
      end else begin
        build_frame($urandom_range(FRAME_LEN - 4, SYNC_LAST_START + 1), 80, 1'b0);
      end
      send_frame();
    end
  endtask

  // The receiver holds off long enough that one result sits in the output
  // register and the next one backs up into the block, which must then stop
  // taking bytes while the sender keeps offering them.
  task automatic test_output_backpressure();
    int f;
    wait_results_drained();
    tx_gaps_on = 1'b0;
    rx_hold_len <= 3 * FRAME_LEN + 200;
    rx_hold_tag <= rx_hold_tag + 1;
    for (f = 0; f < 3; f++) begin
      build_frame($urandom_range(8, 0), 80, 1'b0);
      send_frame();
    end
    wait_results_drained();
    tx_gaps_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_records();
    test_absent_sync();
    test_sync_window_edge();
    test_code_registers();
    test_random_frames(36);
    test_output_backpressure();
    wait_results_drained();

    $display("Covered %0d frames (%0d without a usable sync), %0d results checked,",
             frames_sent, frames_unsynced, results_checked);
    $display("%0d register writes, input gaps, output stalls and a long output hold-off.",
             cfg_writes);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ctdfp_pkg.sv
hw/rtl/ctdfp_ctrl.sv
hw/rtl/ctdfp_dpath.sv
hw/rtl/ctd_frame_parse_calibrate.sv
hw/rtl/ctdfp_checker.sv
dv/ctd_frame_parse_calibrate_tb.sv
